### hw/rtl/rtfv_pkg.sv
// ----------------------------------------------------------------------------
// rtfv_pkg
// Types, widths and helpers shared by the rotation-between-vectors pipeline.
// ----------------------------------------------------------------------------
package rtfv_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int DW         = 16;                 // vector component / matrix entry
    localparam int PW         = 2 * DW;             // component product
    localparam int VW         = 32;                 // cross product component
    localparam int CW         = 33;                 // dot product
    localparam int SW         = 64;                 // squared magnitude, Q(4F)
    localparam int QW         = 32;                 // quotient bits of the divider
    localparam int NW         = SW + QW;            // dividend width
    localparam int EW         = 36;                 // matrix entry before rounding, Q(2F)
    localparam int LIMW       = 31;                 // parallel limit register
    localparam int LIM_SHIFT  = 4 * FRAC_BITS - 30; // Q1.30 -> Q(4F)
    localparam int DIV_STAGES = QW;
    localparam int LANES      = 6;

    typedef enum logic [1:0] {
        CASE_GENERAL      = 2'd0,
        CASE_PARALLEL     = 2'd1,
        CASE_ANTIPARALLEL = 2'd2
    } case_code_t;

    // Side information that travels alongside the division lanes.
    typedef struct packed {
        logic signed [VW-1:0] v0;
        logic signed [VW-1:0] v1;
        logic signed [VW-1:0] v2;
        logic                 par;
        logic                 c_pos;
        logic [LANES-1:0]     neg;
    } side_t;

    // Q(2F) to QF, round half away from zero, clamp to +/-1.0.
    function automatic logic signed [DW-1:0] finish_entry(input logic signed [EW-1:0] x);
        logic [EW-1:0] mag;
        logic [EW-1:0] rnd;
        logic [DW-1:0] m;
        begin
            mag = x[EW-1] ? (~x + EW'(1)) : x;
            rnd = (mag + (EW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (rnd > (EW'(1) << FRAC_BITS)) begin
                m = DW'(1) << FRAC_BITS;
            end else begin
                m = rnd[DW-1:0];
            end
            finish_entry = x[EW-1] ? signed'(~m + DW'(1)) : signed'(m);
        end
    endfunction

endpackage

### hw/rtl/rtfv_div.sv
// ----------------------------------------------------------------------------
// rtfv_div
// Pipelined restoring divider, one quotient bit per stage. The upper part of
// the dividend must be below the divisor, so the quotient fits QW bits.
// ----------------------------------------------------------------------------
module rtfv_div
    import rtfv_pkg::*;
(
    input  logic                  aclk,
    input  logic [DIV_STAGES-1:0] en,
    input  logic [NW-1:0]         num,
    input  logic [SW-1:0]         den,
    output logic [QW-1:0]         quot,
    output logic [SW-1:0]         rem,
    output logic [SW-1:0]         den_out
);

    logic [SW-1:0] rem_reg [DIV_STAGES];
    logic [QW-1:0] low_reg [DIV_STAGES];
    logic [QW-1:0] q_reg   [DIV_STAGES];
    logic [SW-1:0] den_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [SW-1:0] rem_prev;
        logic [QW-1:0] low_prev;
        logic [QW-1:0] q_prev;
        logic [SW-1:0] den_prev;
        logic [SW:0]   trial;
        logic          ge;
        logic [SW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign rem_prev = num[NW-1 -: SW];
            assign low_prev = num[QW-1:0];
            assign q_prev   = '0;
            assign den_prev = den;
        end else begin : g_next
            assign rem_prev = rem_reg[k-1];
            assign low_prev = low_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign den_prev = den_reg[k-1];
        end

        always_comb begin
            trial    = {rem_prev, low_prev[QW-1]};
            ge       = trial >= {1'b0, den_prev};
            rem_next = ge ? SW'(trial - {1'b0, den_prev}) : trial[SW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_prev << 1;
                q_reg[k]   <= {q_prev[QW-2:0], ge};
                den_reg[k] <= den_prev;
            end
        end
    end

    assign quot    = q_reg[DIV_STAGES-1];
    assign rem     = rem_reg[DIV_STAGES-1];
    assign den_out = den_reg[DIV_STAGES-1];

endmodule

### hw/rtl/rotation_from_to_vectors_top.sv
// ----------------------------------------------------------------------------
// rotation_from_to_vectors_top
// Rotation matrix that turns one unit vector into another, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one pair of Q2.14 vectors per clock and returns the Q2.14 rotation
// matrix and a case code for each accepted pair; a new pair is taken every
// cycle for as long as the result side keeps up, and every stage holds its
// word while the output is stalled, so bubbles are squeezed out. Most of the
// pipeline depth comes from the six parallel restoring dividers, which give
// one quotient bit per stage over 32 stages. The parallel limit may only be
// written while the pipeline is empty.
module rotation_from_to_vectors_top
    import rtfv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // from_x, from_y, from_z, to_x, to_y, to_z
    input  logic [6*DW-1:0]   s_tdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic [9*DW-1:0]   m_tdata,
    // case_code
    output logic [1:0]        m_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic [LIMW-1:0]   cfg_data,
    input  logic              cfg_valid,
    output logic              cfg_ready
);

    localparam int ST_N   = 6;
    localparam int ST_F1  = ST_N + DIV_STAGES + 1;
    localparam int ST_OUT = ST_F1 + 1;
    localparam int NS     = ST_OUT + 1;

    logic [NS-1:0]   vld_reg;
    logic [NS-1:0]   en;
    logic [LIMW-1:0] limit_reg;

    // Each stage loads when it is empty or the stage after it moves on.
    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready  = en[0];
    assign m_tvalid  = vld_reg[NS-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            limit_reg <= LIMW'(33);
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 0: component products.
    logic signed [DW-1:0] a [3];
    logic signed [DW-1:0] b [3];
    logic signed [PW-1:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;
    logic signed [PW-1:0] p_xx_reg, p_yy_reg, p_zz_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a[i] = signed'(s_tdata[i*DW +: DW]);
            b[i] = signed'(s_tdata[(3+i)*DW +: DW]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p_yz_reg <= a[1] * b[2];
            p_zy_reg <= a[2] * b[1];
            p_zx_reg <= a[2] * b[0];
            p_xz_reg <= a[0] * b[2];
            p_xy_reg <= a[0] * b[1];
            p_yx_reg <= a[1] * b[0];
            p_xx_reg <= a[0] * b[0];
            p_yy_reg <= a[1] * b[1];
            p_zz_reg <= a[2] * b[2];
        end
    end

    // Stage 1: cross and dot products, exact in Q(2F).
    logic signed [VW-1:0] v1_reg [3];
    logic signed [CW-1:0] c1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            v1_reg[0] <= p_yz_reg - p_zy_reg;
            v1_reg[1] <= p_zx_reg - p_xz_reg;
            v1_reg[2] <= p_xy_reg - p_yx_reg;
            c1_reg    <= CW'(p_xx_reg) + CW'(p_yy_reg) + CW'(p_zz_reg);
        end
    end

    // Stage 2: magnitudes, squares and 1 - c.
    logic [VW-1:0]        vm2_reg [3];
    logic [SW-1:0]        sq2_reg [3];
    logic signed [VW-1:0] v2_reg  [3];
    logic [QW-1:0]        omcm2_reg;
    logic                 omcneg2_reg;
    logic                 cpos2_reg;
    logic [VW-1:0]        vmag    [3];
    logic signed [CW:0]   omc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vmag[i] = v1_reg[i][VW-1] ? (~v1_reg[i] + VW'(1)) : v1_reg[i];
        end
        omc = (CW+1)'(1 <<< (2 * FRAC_BITS)) - (CW+1)'(c1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                vm2_reg[i] <= vmag[i];
                sq2_reg[i] <= SW'(vmag[i]) * SW'(vmag[i]);
                v2_reg[i]  <= v1_reg[i];
            end
            omcm2_reg   <= omc[CW] ? QW'(~omc + (CW+1)'(1)) : QW'(omc);
            omcneg2_reg <= omc[CW];
            cpos2_reg   <= !c1_reg[CW-1];
        end
    end

    // Stage 3: squared sine and the off-diagonal products of v v^T.
    logic [SW-1:0] s2_3_reg;
    logic [SW-1:0] sq3_reg  [3];
    logic [SW-1:0] off3_reg [3];
    logic [QW-1:0] omcm3_reg;
    side_t         side3_reg;
    side_t         side3_next;

    always_comb begin
        side3_next.v0    = v2_reg[0];
        side3_next.v1    = v2_reg[1];
        side3_next.v2    = v2_reg[2];
        side3_next.par   = 1'b0;
        side3_next.c_pos = cpos2_reg;
        // Diagonal terms of v v^T - s2 I are never positive.
        side3_next.neg[0] = !omcneg2_reg;
        side3_next.neg[1] = !omcneg2_reg;
        side3_next.neg[2] = !omcneg2_reg;
        side3_next.neg[3] = v2_reg[0][VW-1] ^ v2_reg[1][VW-1] ^ omcneg2_reg;
        side3_next.neg[4] = v2_reg[0][VW-1] ^ v2_reg[2][VW-1] ^ omcneg2_reg;
        side3_next.neg[5] = v2_reg[1][VW-1] ^ v2_reg[2][VW-1] ^ omcneg2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s2_3_reg    <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            sq3_reg     <= sq2_reg;
            off3_reg[0] <= SW'(vm2_reg[0]) * SW'(vm2_reg[1]);
            off3_reg[1] <= SW'(vm2_reg[0]) * SW'(vm2_reg[2]);
            off3_reg[2] <= SW'(vm2_reg[1]) * SW'(vm2_reg[2]);
            omcm3_reg   <= omcm2_reg;
            side3_reg   <= side3_next;
        end
    end

    // Stage 4: diagonal terms and the parallel test.
    logic [SW-1:0] pm4_reg [LANES];
    logic [SW-1:0] s2_4_reg;
    logic [QW-1:0] omcm4_reg;
    side_t         side4_reg;
    side_t         side4_next;
    logic [SW-1:0] limit_q4f;

    always_comb begin
        limit_q4f      = SW'({limit_reg, LIM_SHIFT'(0)});
        side4_next     = side3_reg;
        side4_next.par = s2_3_reg <= limit_q4f;
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                pm4_reg[i]     <= s2_3_reg - sq3_reg[i];
                pm4_reg[3 + i] <= off3_reg[i];
            end
            s2_4_reg  <= s2_3_reg;
            omcm4_reg <= omcm3_reg;
            side4_reg <= side4_next;
        end
    end

    // Stage 5: (1 - c) times each term, as two 32 x 32 partial products.
    logic [SW-1:0] lo5_reg [LANES];
    logic [SW-1:0] hi5_reg [LANES];
    logic [SW-1:0] s2_5_reg;
    side_t         side5_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            for (int l = 0; l < LANES; l++) begin
                lo5_reg[l] <= SW'(omcm4_reg) * SW'(pm4_reg[l][QW-1:0]);
                hi5_reg[l] <= SW'(omcm4_reg) * SW'(pm4_reg[l][SW-1:QW]);
            end
            s2_5_reg  <= s2_4_reg;
            side5_reg <= side4_reg;
        end
    end

    // Stage 6: dividends.
    logic [NW-1:0] n6_reg [LANES];
    logic [SW-1:0] s2_6_reg;
    side_t         side_reg [DIV_STAGES+1];

    always_ff @(posedge aclk) begin
        if (en[ST_N]) begin
            for (int l = 0; l < LANES; l++) begin
                n6_reg[l] <= {hi5_reg[l], QW'(0)} + NW'(lo5_reg[l]);
            end
            s2_6_reg    <= s2_5_reg;
            side_reg[0] <= side5_reg;
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en[ST_N + k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Division lanes: three diagonal terms, then entries 01, 02 and 12.
    logic [QW-1:0] quot    [LANES];
    logic [SW-1:0] rem     [LANES];
    logic [SW-1:0] den_out [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        rtfv_div u_div (
            .aclk    (aclk),
            .en      (en[ST_N + 1 +: DIV_STAGES]),
            .num     (n6_reg[l]),
            .den     (s2_6_reg),
            .quot    (quot[l]),
            .rem     (rem[l]),
            .den_out (den_out[l])
        );
    end

    // Stage F1: round the quotients and assemble the entries in Q(2F).
    logic signed [EW-1:0] e_reg [9];
    logic                 par_f_reg;
    logic                 cpos_f_reg;
    logic signed [EW-1:0] ts [LANES];
    logic signed [EW-1:0] ve [3];
    logic [QW:0]          tq;
    logic                 up;
    side_t                side_d;

    always_comb begin
        side_d = side_reg[DIV_STAGES];
        for (int l = 0; l < LANES; l++) begin
            up    = {rem[l], 1'b0} >= {1'b0, den_out[l]};
            tq    = {1'b0, quot[l]} + (QW+1)'(up);
            ts[l] = side_d.neg[l] ? -signed'(EW'(tq)) : signed'(EW'(tq));
        end
        ve[0] = EW'(side_d.v0);
        ve[1] = EW'(side_d.v1);
        ve[2] = EW'(side_d.v2);
    end

    always_ff @(posedge aclk) begin
        if (en[ST_F1]) begin
            e_reg[0]   <= (EW'(1) <<< (2 * FRAC_BITS)) + ts[0];
            e_reg[4]   <= (EW'(1) <<< (2 * FRAC_BITS)) + ts[1];
            e_reg[8]   <= (EW'(1) <<< (2 * FRAC_BITS)) + ts[2];
            e_reg[1]   <= ts[3] - ve[2];
            e_reg[3]   <= ts[3] + ve[2];
            e_reg[2]   <= ts[4] + ve[1];
            e_reg[6]   <= ts[4] - ve[1];
            e_reg[5]   <= ts[5] - ve[0];
            e_reg[7]   <= ts[5] + ve[0];
            par_f_reg  <= side_d.par;
            cpos_f_reg <= side_d.c_pos;
        end
    end

    // Output stage: round to QF and saturate, or the (negated) identity.
    logic [9*DW-1:0] m_tdata_reg;
    logic [9*DW-1:0] m_tdata_next;
    case_code_t      m_tuser_reg;
    case_code_t      m_tuser_next;
    logic [DW-1:0]   diag_one;

    always_comb begin
        diag_one = cpos_f_reg ? (DW'(1) << FRAC_BITS) : (~(DW'(1) << FRAC_BITS) + DW'(1));
        for (int e = 0; e < 9; e++) begin
            if (par_f_reg) begin
                m_tdata_next[e*DW +: DW] = (e % 4 == 0) ? diag_one : DW'(0);
            end else begin
                m_tdata_next[e*DW +: DW] = finish_entry(e_reg[e]);
            end
        end
        if (!par_f_reg) begin
            m_tuser_next = CASE_GENERAL;
        end else if (cpos_f_reg) begin
            m_tuser_next = CASE_PARALLEL;
        end else begin
            m_tuser_next = CASE_ANTIPARALLEL;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

### verif/rotation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_checker
// Watches the vector-pair, matrix and limit channels of the rotation block,
// works out the matrix that each accepted pair must give and compares every
// returned word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rotation_checker
    import rtfv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [6*DW-1:0]   s_tdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [9*DW-1:0]   m_tdata,
    input  logic [1:0]        m_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [LIMW-1:0]   cfg_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    output int                mismatches,
    output int                outstanding
);

    typedef struct {
        logic [9*DW-1:0] entries;
        case_code_t      code;
    } rotation_t;

    rotation_t       matrix_queue[$];
    logic [LIMW-1:0] limit_copy;

    function automatic longint unsigned magnitude(input longint x);
        magnitude = x < 0 ? longint'(0) - x : x;
    endfunction

    // Q(2F) to QF, rounding half away from zero and clamping to +/-1.0.
    function automatic logic [DW-1:0] to_entry(input longint x);
        longint unsigned m;
        m = magnitude(x);
        m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (m > (64'd1 << FRAC_BITS)) begin
            m = 64'd1 << FRAC_BITS;
        end
        to_entry = x < 0 ? DW'(-m) : DW'(m);
    endfunction

    function automatic rotation_t predict_rotation(input logic [6*DW-1:0] pair,
                                                   input logic [LIMW-1:0] lim);
        rotation_t       r;
        longint          a[3], b[3], v[3], w[3][3];
        longint          c, omc, e, one;
        longint unsigned s2, q, pm, t, omc_mag;
        logic [127:0]    prod, quo, rm, den;
        bit              par, pneg, tneg;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'($signed(pair[DW*i +: DW]));
            b[i] = longint'($signed(pair[DW*(3+i) +: DW]));
        end
        v[0] = a[1] * b[2] - a[2] * b[1];
        v[1] = a[2] * b[0] - a[0] * b[2];
        v[2] = a[0] * b[1] - a[1] * b[0];
        c = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        s2 = 0;
        for (int i = 0; i < 3; i++) begin
            s2 += magnitude(v[i]) * magnitude(v[i]);
        end
        one = longint'(1) << (2 * FRAC_BITS);
        // The limit is Q1.30 and s2 is Q(4F), so the low bits of s2 break ties.
        q   = s2 >> LIM_SHIFT;
        par = (q < lim) || (q == lim && s2[LIM_SHIFT-1:0] == 0);
        if (par) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r.entries[DW*(3*i+j) +: DW] = to_entry(i == j ? (c >= 0 ? one : -one) : 0);
                end
            end
            r.code = c >= 0 ? CASE_PARALLEL : CASE_ANTIPARALLEL;
            return r;
        end
        w[0][0] = 0;     w[0][1] = -v[2]; w[0][2] = v[1];
        w[1][0] = v[2];  w[1][1] = 0;     w[1][2] = -v[0];
        w[2][0] = -v[1]; w[2][1] = v[0];  w[2][2] = 0;
        omc     = one - c;
        omc_mag = magnitude(omc);
        den     = {64'd0, s2};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i == j) begin
                    pm   = s2 - magnitude(v[i]) * magnitude(v[i]);
                    pneg = pm != 0;
                end else begin
                    pm   = magnitude(v[i]) * magnitude(v[j]);
                    pneg = ((v[i] < 0) != (v[j] < 0)) && pm != 0;
                end
                prod = {64'd0, omc_mag} * {64'd0, pm};
                quo  = prod / den;
                rm   = prod % den;
                t    = quo[63:0];
                if (rm >= den - rm) begin
                    t++;
                end
                tneg = pneg != (omc < 0);
                e = w[i][j] + (tneg ? -longint'(t) : longint'(t));
                if (i == j) begin
                    e += one;
                end
                r.entries[DW*(3*i+j) +: DW] = to_entry(e);
            end
        end
        r.code = CASE_GENERAL;
        return r;
    endfunction

    assign outstanding = matrix_queue.size();

    always @(posedge aclk) begin
        rotation_t want;
        int        errors;
        errors = 0;
        if (!aresetn) begin
            limit_copy <= LIMW'(33);
            mismatches <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_copy <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                matrix_queue = {matrix_queue, predict_rotation(s_tdata, limit_copy)};
            end
            if (m_tvalid && m_tready) begin
                if (matrix_queue.size() == 0) begin
                    $display("%0t: matrix word with nothing expected: %h / %0d",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = matrix_queue.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (m_tdata[DW*k +: DW] !== want.entries[DW*k +: DW]) begin
                            $display("%0t: entry m%0d%0d expected %0d, got %0d", $time,
                                     k / 3, k % 3, $signed(want.entries[DW*k +: DW]),
                                     $signed(m_tdata[DW*k +: DW]));
                            errors++;
                        end
                    end
                    if (m_tuser !== want.code) begin
                        $display("%0t: case code expected %0d, got %0d",
                                 $time, want.code, m_tuser);
                        errors++;
                    end
                end
            end
            if (errors != 0) begin
                mismatches <= mismatches + errors;
            end
        end
    end

endmodule

### verif/tb_rotation_from_to_vectors_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_from_to_vectors_top
// Drives vector pairs into the rotation block under several parallel limits.
// Directed pairs cover axes, exact and near (anti)parallel pairs and range
// extremes; random pairs mix unit vectors, near-aligned pairs and raw words,
// with random gaps and stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_rotation_from_to_vectors_top;
    import rtfv_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASE_ITEMS    = 205;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic [6*DW-1:0]   s_tdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [9*DW-1:0]   m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [LIMW-1:0]   cfg_data = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    int                mismatches;
    int                outstanding;
    int                idle_cycles = 0;
    bit                hold_request = 1'b0;

    always #6 aclk = ~aclk;

    rotation_from_to_vectors_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
    );

    rotation_checker u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        bit seen;
        @(posedge aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                int n;
                n = $urandom_range(0, 6);
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                seen = m_tvalid;
                @(posedge aclk);
            end while (!seen);
        end
    end

    // Ready is sampled mid-cycle, where all inputs have settled.
    task automatic send_pair(input logic [6*DW-1:0] pair);
        int gap;
        bit seen;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) begin
            gap = 0;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= pair;
        s_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
            seen = s_tready;
            @(posedge aclk);
        end while (!seen);
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMW-1:0] lim);
        bit seen;
        wait_drained();
        cfg_data  <= lim;
        cfg_valid <= 1'b1;
        do begin
            @(negedge aclk);
            seen = cfg_ready;
            @(posedge aclk);
        end while (!seen);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [6*DW-1:0] make_pair(input logic [3*DW-1:0] src,
                                                  input logic [3*DW-1:0] dst);
        make_pair = {dst, src};
    endfunction

    function automatic logic [3*DW-1:0] vec(input int x, input int y, input int z);
        vec = {DW'(z), DW'(y), DW'(x)};
    endfunction

    function automatic logic [3*DW-1:0] random_unit();
        real rx, ry, rz, n;
        rx = $itor($urandom_range(0, 2000)) - 1000.0;
        ry = $itor($urandom_range(0, 2000)) - 1000.0;
        rz = $itor($urandom_range(0, 2000)) - 1000.0;
        n  = $sqrt(rx * rx + ry * ry + rz * rz);
        if (n < 1.0) begin
            return vec(16384, 0, 0);
        end
        return vec($rtoi(rx / n * 16384.0), $rtoi(ry / n * 16384.0), $rtoi(rz / n * 16384.0));
    endfunction

    // Optionally negates, then nudges each component by a small amount, keeping the pair nearly aligned or opposite.
    function automatic logic [3*DW-1:0] nudge(input logic [3*DW-1:0] u, input bit flip,
                                              input int spread);
        logic [3*DW-1:0] r;
        int comp;
        for (int i = 0; i < 3; i++) begin
            comp = int'($signed(u[DW*i +: DW]));
            if (flip) begin
                comp = -comp;
            end
            comp = comp + $urandom_range(0, 2 * spread) - spread;
            r[DW*i +: DW] = DW'(comp);
        end
        return r;
    endfunction

    task automatic random_phase(input int count, input bit with_hold);
        logic [3*DW-1:0] u;
        int pick;
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == 20) begin
                hold_request = 1'b1;
            end
            pick = $urandom_range(0, 99);
            u = random_unit();
            if (pick < 50) begin
                send_pair(make_pair(u, random_unit()));
            end else if (pick < 65) begin
                send_pair(make_pair(u, nudge(u, 1'b0, $urandom_range(0, 1) ? 2 : 60)));
            end else if (pick < 80) begin
                send_pair(make_pair(u, nudge(u, 1'b1, $urandom_range(0, 1) ? 2 : 60)));
            end else if (pick < 85) begin
                send_pair(make_pair(u, u));
            end else begin
                send_pair({$urandom(), $urandom(), $urandom()});
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pairs under the reset limit.
        send_pair(make_pair(vec(16384, 0, 0), vec(16384, 0, 0)));
        send_pair(make_pair(vec(16384, 0, 0), vec(-16384, 0, 0)));
        send_pair(make_pair(vec(16384, 0, 0), vec(0, 16384, 0)));
        send_pair(make_pair(vec(0, 16384, 0), vec(0, 0, 16384)));
        send_pair(make_pair(vec(0, 0, 16384), vec(16384, 0, 0)));
        send_pair(make_pair(vec(0, 0, -16384), vec(0, -16384, 0)));
        send_pair(make_pair(vec(16384, 0, 0), vec(16384, 1, 0)));
        send_pair(make_pair(vec(16384, 0, 0), vec(16384, 0, 30)));
        send_pair(make_pair(vec(16384, 0, 0), vec(-16384, 2, 1)));
        send_pair(make_pair(vec(16384, 0, 0), vec(-16384, 0, 40)));
        send_pair(make_pair(vec(9459, 9459, 9459), vec(-9459, -9459, 9459)));
        send_pair(make_pair(vec(0, 0, 0), vec(0, 0, 0)));
        send_pair(make_pair(vec(0, 0, 0), vec(16384, 0, 0)));
        send_pair(make_pair(vec(-32768, -32768, -32768), vec(32767, 32767, 32767)));
        send_pair(make_pair(vec(32767, -32768, 32767), vec(-32768, 32767, 0)));
        send_pair(make_pair(vec(-32768, 0, 0), vec(0, 32767, 0)));
        send_pair({6{16'hffff}});
        send_pair({6{16'haaaa}});
        send_pair({6{16'h5555}});
        send_pair(make_pair(vec(11585, 11585, 0), vec(0, 11585, -11585)));

        write_limit(LIMW'(0));
        send_pair(make_pair(vec(16384, 0, 0), vec(16384, 1, 0)));
        random_phase(PHASE_ITEMS, 1'b1);

        write_limit(LIMW'(1073741824));
        send_pair(make_pair(vec(16384, 0, 0), vec(0, 16384, 0)));
        random_phase(PHASE_ITEMS, 1'b0);

        write_limit(LIMW'($urandom_range(1, 1 << 20)));
        random_phase(PHASE_ITEMS, 1'b0);

        write_limit(LIMW'(33));
        random_phase(PHASE_ITEMS, 1'b0);

        wait_drained();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
